FILE: rtl/tcw_pkg.sv
// Package for the text console writer: grid geometry, command codes,
// back-end states and the command record queued between front and back.
// No dependencies.
package tcw_pkg;

  // Grid geometry
  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = ROWS * COLUMNS;
  localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  // Field widths of the item ports
  localparam int KIND_W = 2;
  localparam int ROW_W = 5;
  localparam int COL_W = 7;
  localparam int CELL_W = 16;

  // Character codes
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Item kinds on the input port
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  // Command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register map (register index)
  localparam logic REG_DEFAULT_ATTR = 1'b0;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_LF,
    OP_CR,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t op;
    logic [7:0] ch;
    logic [7:0] attr;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN,
    ST_BLANK
  } state_t;

endpackage

FILE: rtl/text_console_writer.sv
// Top level of the text console writer: configuration register, front end,
// command queue and back end. Depends on tcw_pkg, tcw_front, tcw_cmd_queue,
// tcw_back.
//
// Usage: drive an item on kind/char_code/use_own_color/fore_color/read_row/
// read_col with start high; the item is taken on a clock edge with start high
// and busy low. Every item yields exactly one result, shown for one cycle
// with done high on cell_data, cursor_row, cursor_col and scrolled. The
// receiver has no back-pressure and must take each result when done is high.
// A printable byte, carriage return, line feed without scroll, or an
// out-of-range read is popped in idle and finished in the execute state; a
// cell read adds the read state for the registered memory read. A line feed
// or line wrap on the last row scrolls the grid (one cell move per cycle,
// then a row of blanks). A clear writes every cell once. The back end pops
// one command at a time, only when idle, and has a single cell write port.
// A two-entry queue lets items be taken while a sweep runs; busy rises
// when it fills. Reset homes the cursor and sets default_attribute to 7; the
// cell memory holds no defined value until a clear. default_attribute sits
// at APB address 0 and may be written only while the block is idle.
module text_console_writer (
  input  logic                         clk,
  input  logic                         rst,
  // Item channel
  input  logic                         start,
  output logic                         busy,
  input  logic [tcw_pkg::KIND_W-1:0]   kind,
  input  logic [7:0]                   char_code,
  input  logic                         use_own_color,
  input  logic [3:0]                   fore_color,
  input  logic [tcw_pkg::ROW_W-1:0]    read_row,
  input  logic [tcw_pkg::COL_W-1:0]    read_col,
  // Result channel
  output logic                         done,
  output logic [tcw_pkg::CELL_W-1:0]   cell_data,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col,
  output logic                         scrolled,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [7:0] default_attribute;
  logic cfg_write;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  tcw_pkg::cmd_t push_cmd;
  tcw_pkg::cmd_t head_cmd;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attribute <= 8'd7;
    end else if (cfg_write && paddr[2] == tcw_pkg::REG_DEFAULT_ATTR) begin
      default_attribute <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tcw_pkg::REG_DEFAULT_ATTR) begin
      prdata = {24'd0, default_attribute};
    end
  end

  tcw_front u_front (
    .start             (start),
    .kind              (kind),
    .char_code         (char_code),
    .use_own_color     (use_own_color),
    .fore_color        (fore_color),
    .read_row          (read_row),
    .read_col          (read_col),
    .default_attribute (default_attribute),
    .q_full            (q_full),
    .busy              (busy),
    .push              (push),
    .cmd               (push_cmd)
  );

  tcw_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  tcw_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head_cmd          (head_cmd),
    .q_empty           (q_empty),
    .default_attribute (default_attribute),
    .pop               (pop),
    .done              (done),
    .cell_data         (cell_data),
    .cursor_row        (cursor_row),
    .cursor_col        (cursor_col),
    .scrolled          (scrolled)
  );

endmodule

FILE: rtl/tcw_front.sv
// Front end of the text console writer: accepts items and decodes them into
// queued commands (operation, cell value parts, read address).
// Depends on tcw_pkg.
module tcw_front (
  input  logic                      start,
  input  logic [tcw_pkg::KIND_W-1:0] kind,
  input  logic [7:0]                char_code,
  input  logic                      use_own_color,
  input  logic [3:0]                fore_color,
  input  logic [tcw_pkg::ROW_W-1:0] read_row,
  input  logic [tcw_pkg::COL_W-1:0] read_col,
  input  logic [7:0]                default_attribute,
  input  logic                      q_full,
  output logic                      busy,
  output logic                      push,
  output tcw_pkg::cmd_t             cmd
);

  // Hold off new items while the queue has no room
  assign busy = q_full;
  assign push = start && !q_full;

  // Classify the item
  always_comb begin
    cmd.op = tcw_pkg::OP_NOP;
    cmd.ch = char_code;
    cmd.attr = use_own_color ? {4'b0000, fore_color} : default_attribute;
    cmd.addr = tcw_pkg::ADDR_W'(
      tcw_pkg::ADDR_W'(read_row) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
      + tcw_pkg::ADDR_W'(read_col));
    unique case (kind)
      tcw_pkg::KIND_WRITE: begin
        if (char_code == tcw_pkg::CH_LF) begin
          cmd.op = tcw_pkg::OP_LF;
        end else if (char_code == tcw_pkg::CH_CR) begin
          cmd.op = tcw_pkg::OP_CR;
        end else begin
          cmd.op = tcw_pkg::OP_PUT;
        end
      end
      tcw_pkg::KIND_CLEAR: begin
        cmd.op = tcw_pkg::OP_CLEAR;
      end
      tcw_pkg::KIND_READ: begin
        // Out-of-range reads return zero and change nothing
        if (32'(read_row) < tcw_pkg::ROWS && 32'(read_col) < tcw_pkg::COLUMNS) begin
          cmd.op = tcw_pkg::OP_READ;
        end else begin
          cmd.op = tcw_pkg::OP_NOP;
        end
      end
      default: begin
        cmd.op = tcw_pkg::OP_NOP;
      end
    endcase
  end

endmodule

FILE: rtl/tcw_cmd_queue.sv
// Short command queue between the front and back ends of the console writer.
// Depends on tcw_pkg.
module tcw_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  input  logic          pop,
  output tcw_pkg::cmd_t head_cmd,
  output logic          empty,
  output logic          full
);

  tcw_pkg::cmd_t entries [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0] wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0] rd_ptr;
  logic [tcw_pkg::QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full = (count == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign head_cmd = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == tcw_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == tcw_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= tcw_pkg::QUEUE_DEPTH)
    else $error("queue occupancy out of range");

endmodule

FILE: rtl/tcw_back.sv
// Back end of the text console writer: owns the cell memory and the cursor,
// executes queued commands including scroll and clear sweeps, drives results.
// Depends on tcw_pkg.
module tcw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  tcw_pkg::cmd_t               head_cmd,
  input  logic                        q_empty,
  input  logic [7:0]                  default_attribute,
  output logic                        pop,
  output logic                        done,
  output logic [tcw_pkg::CELL_W-1:0]  cell_data,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
  output logic [tcw_pkg::COL_W-1:0]   cursor_col,
  output logic                        scrolled
);

  localparam logic [tcw_pkg::ADDR_W-1:0] ROW_STEP = tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::ADDR_W-1:0] SCROLL_LAST = tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_CELLS - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] SCROLL_END = tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_CELLS);
  localparam logic [tcw_pkg::ADDR_W-1:0] CELL_LAST = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
  localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
  localparam logic [tcw_pkg::COL_W-1:0] COL_FULL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);

  // Cell memory
  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata;
  logic                       mem_we;
  logic [tcw_pkg::ADDR_W-1:0] mem_waddr;
  logic [tcw_pkg::ADDR_W-1:0] mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;

  // Control and cursor registers
  tcw_pkg::state_t state, state_next;
  tcw_pkg::cmd_t cmd, cmd_next;
  logic [tcw_pkg::ROW_W-1:0] row, row_next;
  logic [tcw_pkg::COL_W-1:0] col, col_next;
  logic [tcw_pkg::ADDR_W-1:0] base, base_next;
  logic [tcw_pkg::ADDR_W-1:0] ptr, ptr_next;
  logic [tcw_pkg::ADDR_W-1:0] wr_addr, wr_addr_next;
  logic pend, pend_next;
  logic scr, scr_next;
  logic done_next;
  logic [tcw_pkg::CELL_W-1:0] cell_data_next;
  logic emit;
  logic [tcw_pkg::CELL_W-1:0] blank;

  assign blank = {default_attribute, tcw_pkg::CH_SPACE};

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Next state, memory control and results
  always_comb begin
    state_next = state;
    cmd_next = cmd;
    row_next = row;
    col_next = col;
    base_next = base;
    ptr_next = ptr;
    wr_addr_next = wr_addr;
    pend_next = pend;
    scr_next = scr;
    cell_data_next = '0;
    emit = 1'b0;
    pop = 1'b0;
    mem_we = 1'b0;
    mem_waddr = ptr;
    mem_wdata = blank;
    mem_raddr = cmd.addr;

    unique case (state)
      tcw_pkg::ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          cmd_next = head_cmd;
          scr_next = 1'b0;
          state_next = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        unique case (cmd.op)
          tcw_pkg::OP_PUT: begin
            if (col >= COL_FULL) begin
              // Line full: take a new line first, scrolling on the last row
              col_next = '0;
              if (row < ROW_LAST) begin
                row_next = row + 1'b1;
                base_next = base + ROW_STEP;
              end else begin
                scr_next = 1'b1;
                ptr_next = '0;
                pend_next = 1'b0;
                state_next = tcw_pkg::ST_SCROLL;
              end
            end else begin
              mem_we = 1'b1;
              mem_waddr = base + tcw_pkg::ADDR_W'(col);
              mem_wdata = {cmd.attr, cmd.ch};
              col_next = col + 1'b1;
              emit = 1'b1;
              state_next = tcw_pkg::ST_IDLE;
            end
          end
          tcw_pkg::OP_LF: begin
            col_next = '0;
            if (row < ROW_LAST) begin
              row_next = row + 1'b1;
              base_next = base + ROW_STEP;
              emit = 1'b1;
              state_next = tcw_pkg::ST_IDLE;
            end else begin
              scr_next = 1'b1;
              ptr_next = '0;
              pend_next = 1'b0;
              state_next = tcw_pkg::ST_SCROLL;
            end
          end
          tcw_pkg::OP_CR: begin
            col_next = '0;
            emit = 1'b1;
            state_next = tcw_pkg::ST_IDLE;
          end
          tcw_pkg::OP_CLEAR: begin
            row_next = '0;
            col_next = '0;
            base_next = '0;
            ptr_next = '0;
            state_next = tcw_pkg::ST_BLANK;
          end
          tcw_pkg::OP_READ: begin
            mem_raddr = cmd.addr;
            state_next = tcw_pkg::ST_READ;
          end
          default: begin
            emit = 1'b1;
            state_next = tcw_pkg::ST_IDLE;
          end
        endcase
      end
      tcw_pkg::ST_READ: begin
        cell_data_next = rdata;
        emit = 1'b1;
        state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SCROLL: begin
        // Read one row below, write the cell read in the previous cycle
        mem_raddr = ptr + ROW_STEP;
        wr_addr_next = ptr;
        pend_next = 1'b1;
        if (pend) begin
          mem_we = 1'b1;
          mem_waddr = wr_addr;
          mem_wdata = rdata;
        end
        ptr_next = ptr + 1'b1;
        if (ptr == SCROLL_LAST) begin
          state_next = tcw_pkg::ST_DRAIN;
        end
      end
      tcw_pkg::ST_DRAIN: begin
        mem_we = 1'b1;
        mem_waddr = wr_addr;
        mem_wdata = rdata;
        pend_next = 1'b0;
        ptr_next = SCROLL_END;
        state_next = tcw_pkg::ST_BLANK;
      end
      tcw_pkg::ST_BLANK: begin
        // Fill with blanks up to the last cell
        mem_we = 1'b1;
        mem_waddr = ptr;
        mem_wdata = blank;
        ptr_next = ptr + 1'b1;
        if (ptr == CELL_LAST) begin
          if (cmd.op == tcw_pkg::OP_PUT) begin
            state_next = tcw_pkg::ST_EXEC;
          end else begin
            emit = 1'b1;
            state_next = tcw_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase

    done_next = emit;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_IDLE;
      row <= '0;
      col <= '0;
      base <= '0;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      row <= row_next;
      col <= col_next;
      base <= base_next;
      pend <= pend_next;
      done <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    ptr <= ptr_next;
    wr_addr <= wr_addr_next;
    scr <= scr_next;
    if (emit) begin
      cell_data <= cell_data_next;
      cursor_row <= row_next;
      cursor_col <= col_next;
      scrolled <= scr_next;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_base_tracks_row: assert property (@(posedge clk) disable iff (rst)
    32'(base) == 32'(row) * tcw_pkg::COLUMNS)
    else $error("row base address out of step with cursor row");
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    row <= ROW_LAST && col <= COL_FULL)
    else $error("cursor out of range");
  a_pop_from_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == tcw_pkg::ST_EXEC)
    else $error("command popped without entering execution");

endmodule
